### rtl/core/ocp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocp_pkg
// shared types, constants and tables of the orbit camera pose block
// ---------------------------------------------------------------------------
package ocp_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_YAW_GAIN   = 2'd0;
   localparam logic [1:0] CSR_PITCH_GAIN = 2'd1;
   localparam logic [1:0] CSR_LIFT       = 2'd2;
   localparam logic [1:0] CSR_DISTANCE   = 2'd3;

   // angle constants, yaw and pitch in 2^-16 degree
   // a full turn is 45 * 2^19, so the wrap only reduces the bits from 19 up modulo 45
   localparam logic [5:0]         YAW_HI_MOD  = 6'd45;
   localparam logic signed [23:0] YAW_HI_BIAS = 24'sd2949120;  // 45 * 2^16, keeps it positive
   localparam logic [22:0]        YAW_RECIP   = 23'd5965232;   // floor(2^28 / 45)
   localparam logic signed [40:0] PLIM   = 41'sd5832704;

   // sine unit angles in 2^-17 degree
   localparam logic signed [27:0] FULL17 = 28'sd47185920;
   localparam logic signed [27:0] HALF17 = 28'sd23592960;
   localparam logic signed [27:0] Q90_17 = 28'sd11796480;
   localparam logic [24:0]        RAD_Q30 = 25'd18740330;
   localparam logic [30:0]        ONE30  = 31'h4000_0000;
   localparam logic [2:0]         SIN_TERMS_LAST = 3'd4;

   // controller sequencing limits
   localparam logic [2:0] SIN_LAST   = 3'd7;
   localparam logic [3:0] MSTEP_LAST = 4'd8;

   typedef struct packed {
      logic       load;      // accept word, issue yaw product
      logic       ystep;     // take yaw step, start yaw wrap, issue pitch product
      logic       pstep;     // take pitch step
      logic       sin_go;
      logic [2:0] sin_sel;
      logic       mul_en;
      logic [3:0] mstep;
      logic       out_load;
   } ocp_cmd_type;

   typedef struct packed {
      logic mod_busy;
      logic sin_done;
   } ocp_status_type;

   // taylor divisors, highest term first
   function automatic logic [6:0] sin_div(input logic [2:0] i);
      case (i)
         3'd0: sin_div = 7'd110;
         3'd1: sin_div = 7'd72;
         3'd2: sin_div = 7'd42;
         3'd3: sin_div = 7'd20;
         default: sin_div = 7'd6;
      endcase
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [29:0] sin_recip(input logic [2:0] i);
      case (i)
         3'd0: sin_recip = 30'd39045157;
         3'd1: sin_recip = 30'd59652323;
         3'd2: sin_recip = 30'd102261126;
         3'd3: sin_recip = 30'd214748364;
         default: sin_recip = 30'd715827882;
      endcase
   endfunction

endpackage

### rtl/core/ocp_sin.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocp_sin
// iterative sine unit: q2.30 result of an angle in 2^-17 degree
// ---------------------------------------------------------------------------
module ocp_sin import ocp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [27:0] angle,
   output logic               done,
   output logic signed [31:0] result
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RED  = 4'd1;
   localparam logic [3:0] S_X    = 4'd2;
   localparam logic [3:0] S_X2   = 4'd3;
   localparam logic [3:0] S_T    = 4'd4;
   localparam logic [3:0] S_M1   = 4'd5;
   localparam logic [3:0] S_M2   = 4'd6;
   localparam logic [3:0] S_M3   = 4'd7;
   localparam logic [3:0] S_M4   = 4'd8;
   localparam logic [3:0] S_S    = 4'd9;
   localparam logic [3:0] S_F    = 4'd10;

   logic [3:0]         st_ff, st_in;
   logic [2:0]         i_ff, i_in;
   logic               done_ff, done_in;
   logic signed [27:0] ang_ff;
   logic [23:0]        ared_ff;
   logic               neg_ff;
   logic [63:0]        prod_ff, prod_in;
   logic [30:0]        x_ff, t_ff;
   logic [31:0]        x2_ff, p_ff;
   logic [29:0]        q0_ff;
   logic [7:0]         r_ff;
   logic signed [31:0] res_ff;
   logic [31:0]        mul_a, mul_b;
   logic signed [27:0] a_wrap, a_half, a_fold;
   logic               half_neg;
   logic [36:0]        qd;
   logic [31:0]        rdiff;
   logic [30:0]        q_full;
   logic [31:0]        s_val;

   // fold into the first quadrant
   always_comb begin
      if (ang_ff < 0) begin
         a_wrap = ang_ff + FULL17;
      end else if (ang_ff >= FULL17) begin
         a_wrap = ang_ff - FULL17;
      end else begin
         a_wrap = ang_ff;
      end
   end
   assign half_neg = (a_wrap >= HALF17);
   assign a_half   = half_neg ? a_wrap - HALF17 : a_wrap;
   assign a_fold   = (a_half > Q90_17) ? HALF17 - a_half : a_half;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (st_ff)
         S_X: begin
            mul_a = {8'd0, ared_ff};
            mul_b = {7'd0, RAD_Q30};
         end
         S_X2: begin
            mul_a = {1'b0, prod_ff[47:17]};
            mul_b = {1'b0, prod_ff[47:17]};
         end
         S_M1: begin
            mul_a = x2_ff;
            mul_b = {1'b0, t_ff};
         end
         S_M2: begin
            mul_a = prod_ff[61:30];
            mul_b = {2'd0, sin_recip(i_ff)};
         end
         S_S: begin
            mul_a = {1'b0, x_ff};
            mul_b = {1'b0, t_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // remainder of the reciprocal quotient, true value below twice the divisor
   assign qd     = prod_ff[61:32] * sin_div(i_ff);
   assign rdiff  = p_ff - qd[31:0];
   assign q_full = {1'b0, q0_ff} + {30'd0, (r_ff >= {1'b0, sin_div(i_ff)})};
   assign s_val  = (prod_ff[61:30] > {1'b0, ONE30}) ? {1'b0, ONE30} : prod_ff[61:30];

   always_comb begin
      st_in   = st_ff;
      i_in    = i_ff;
      done_in = 1'b0;
      case (st_ff)
         S_IDLE: if (start) st_in = S_RED;
         S_RED:  st_in = S_X;
         S_X:    st_in = S_X2;
         S_X2:   st_in = S_T;
         S_T: begin
            i_in  = '0;
            st_in = S_M1;
         end
         S_M1:   st_in = S_M2;
         S_M2:   st_in = S_M3;
         S_M3:   st_in = S_M4;
         S_M4: begin
            i_in  = i_ff + 3'd1;
            st_in = (i_ff == SIN_TERMS_LAST) ? S_S : S_M1;
         end
         S_S:    st_in = S_F;
         S_F: begin
            done_in = 1'b1;
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         i_ff    <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         i_ff    <= i_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (st_ff == S_IDLE && start) ang_ff <= angle;
      if (st_ff == S_RED) begin
         ared_ff <= a_fold[23:0];
         neg_ff  <= half_neg;
      end
      if (st_ff == S_X2) x_ff <= prod_ff[47:17];
      if (st_ff == S_T) begin
         x2_ff <= prod_ff[61:30];
         t_ff  <= ONE30;
      end
      if (st_ff == S_M2) p_ff <= prod_ff[61:30];
      if (st_ff == S_M3) begin
         q0_ff <= prod_ff[61:32];
         r_ff  <= rdiff[7:0];
      end
      if (st_ff == S_M4) t_ff <= ONE30 - q_full;
      if (st_ff == S_F) res_ff <= neg_ff ? -$signed(s_val) : $signed(s_val);
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### rtl/core/ocp_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocp_dp
// datapath: csr registers, angle state, yaw wrap unit, shared multiplier
// ---------------------------------------------------------------------------
module ocp_dp import ocp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ocp_cmd_type        cmd,
   output ocp_status_type     status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic signed [31:0] req_delta_yaw,
   input  logic signed [31:0] req_delta_pitch,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   output logic signed [31:0] rsp_cam_x,
   output logic signed [31:0] rsp_cam_y,
   output logic signed [31:0] rsp_cam_z,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);

   localparam logic [2:0] SIN_SY = 3'd0;
   localparam logic [2:0] SIN_CY = 3'd1;
   localparam logic [2:0] SIN_SP = 3'd2;
   localparam logic [2:0] SIN_CP = 3'd3;
   localparam logic [2:0] SIN_SA = 3'd4;
   localparam logic [2:0] SIN_CA = 3'd5;
   localparam logic [2:0] SIN_SB = 3'd6;
   localparam logic [2:0] SIN_CB = 3'd7;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         sat32 = v[31:0];
      end else begin
         sat32 = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
      logic signed [33:0] r;
      r = {v[32], v} + 34'sd16384;
      if (r[33:30] == 4'b0000 || r[33:30] == 4'b1111) begin
         to_q15 = r[30:15];
      end else begin
         to_q15 = r[33] ? 16'sh8000 : 16'sh7FFF;
      end
   endfunction

   // csr registers
   logic [23:0]        yaw_gain_ff, pitch_gain_ff;
   logic signed [31:0] lift_ff;
   logic [30:0]        dist_ff;
   // frame state
   logic [24:0]        yaw_ff;
   logic signed [23:0] pitch_ff;
   // captured word and working values
   logic signed [31:0] dp_ff, tx_ff, ty_ff, tz_ff, dcp_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [31:0] sin_ff [8];
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;
   // yaw wrap unit
   logic [22:0]        mod_hi_ff;
   logic [18:0]        mod_lo_ff;
   logic [16:0]        mod_q_ff;
   logic               mod_cnt_ff;
   logic               mod_busy_ff;
   logic signed [23:0] yaw_hi_sum;
   logic [45:0]        mod_prod;
   logic [22:0]        mod_sub, mod_rem;
   logic [5:0]         rem_fix;
   logic [24:0]        yaw_fix;
   logic signed [40:0] yaw_sum, pitch_sum;
   logic signed [31:0] shv;
   logic signed [27:0] sin_angle, yaw2, ha;
   logic               sin_done;
   logic signed [31:0] sin_res;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.load) begin
         mul_a = {req_delta_yaw[31], req_delta_yaw};
         mul_b = {9'd0, yaw_gain_ff};
      end else if (cmd.ystep) begin
         mul_a = {dp_ff[31], dp_ff};
         mul_b = {9'd0, pitch_gain_ff};
      end else if (cmd.mul_en) begin
         case (cmd.mstep)
            4'd0: begin
               mul_a = {2'd0, dist_ff};
               mul_b = {sin_ff[SIN_CP][31], sin_ff[SIN_CP]};
            end
            4'd1: begin
               mul_a = {2'd0, dist_ff};
               mul_b = {sin_ff[SIN_SP][31], sin_ff[SIN_SP]};
            end
            4'd2: begin
               mul_a = {dcp_ff[31], dcp_ff};
               mul_b = {sin_ff[SIN_SY][31], sin_ff[SIN_SY]};
            end
            4'd3: begin
               mul_a = {dcp_ff[31], dcp_ff};
               mul_b = {sin_ff[SIN_CY][31], sin_ff[SIN_CY]};
            end
            4'd4: begin
               mul_a = {sin_ff[SIN_CA][31], sin_ff[SIN_CA]};
               mul_b = {sin_ff[SIN_SB][31], sin_ff[SIN_SB]};
            end
            4'd5: begin
               mul_a = {sin_ff[SIN_SA][31], sin_ff[SIN_SA]};
               mul_b = {sin_ff[SIN_CB][31], sin_ff[SIN_CB]};
            end
            4'd6: begin
               mul_a = {sin_ff[SIN_SA][31], sin_ff[SIN_SA]};
               mul_b = {sin_ff[SIN_SB][31], sin_ff[SIN_SB]};
            end
            4'd7: begin
               mul_a = {sin_ff[SIN_CA][31], sin_ff[SIN_CA]};
               mul_b = {sin_ff[SIN_CB][31], sin_ff[SIN_CB]};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end
   assign prod_in = mul_a * mul_b;
   assign shv     = prod_ff[61:30];

   // angle updates
   assign yaw_sum   = $signed({16'd0, yaw_ff}) + $signed({prod_ff[55], prod_ff[55:16]});
   assign pitch_sum = $signed({{17{pitch_ff[23]}}, pitch_ff})
                      - $signed({prod_ff[55], prod_ff[55:16]});

   // yaw wrap: low 19 bits pass, biased high part reduced mod 45 by reciprocal
   assign yaw_hi_sum = $signed({{2{yaw_sum[40]}}, yaw_sum[40:19]}) + YAW_HI_BIAS;
   assign mod_prod   = mod_hi_ff * YAW_RECIP;
   assign mod_sub    = mod_q_ff * YAW_HI_MOD;
   assign mod_rem    = mod_hi_ff - mod_sub;   // below twice the modulus
   assign rem_fix    = (mod_rem[6:0] >= {1'b0, YAW_HI_MOD})
                       ? 6'(mod_rem[6:0] - {1'b0, YAW_HI_MOD}) : mod_rem[5:0];
   assign yaw_fix    = {rem_fix, mod_lo_ff};

   // sine angle select
   assign yaw2 = $signed({2'd0, yaw_ff, 1'b0});
   assign ha   = (yaw_ff != '0) ? $signed({3'd0, yaw_ff}) - Q90_17 : Q90_17;
   always_comb begin
      case (cmd.sin_sel)
         SIN_SY: sin_angle = yaw2;
         SIN_CY: sin_angle = yaw2 + Q90_17;
         SIN_SP: sin_angle = {{3{pitch_ff[23]}}, pitch_ff, 1'b0};
         SIN_CP: sin_angle = {{3{pitch_ff[23]}}, pitch_ff, 1'b0} + Q90_17;
         SIN_SA: sin_angle = ha;
         SIN_CA: sin_angle = ha + Q90_17;
         SIN_SB: sin_angle = {{4{pitch_ff[23]}}, pitch_ff};
         default: sin_angle = {{4{pitch_ff[23]}}, pitch_ff} + Q90_17;
      endcase
   end

   ocp_sin u_sin (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.sin_go),
      .angle  (sin_angle),
      .done   (sin_done),
      .result (sin_res)
   );

   assign status.mod_busy = mod_busy_ff;
   assign status.sin_done = sin_done;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_gain_ff   <= 24'd65536;
         pitch_gain_ff <= 24'd65536;
         lift_ff       <= 32'sd65536;
         dist_ff       <= 31'd327680;
         yaw_ff        <= '0;
         pitch_ff      <= '0;
         mod_busy_ff   <= 1'b0;
         mod_cnt_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_YAW_GAIN:   yaw_gain_ff   <= csr_data[23:0];
               CSR_PITCH_GAIN: pitch_gain_ff <= csr_data[23:0];
               CSR_LIFT:       lift_ff       <= csr_data;
               CSR_DISTANCE:   dist_ff       <= csr_data[30:0];
               default:        dist_ff       <= dist_ff;
            endcase
         end
         if (cmd.ystep) begin
            mod_busy_ff <= 1'b1;
            mod_cnt_ff  <= 1'b0;
         end else if (mod_busy_ff) begin
            mod_cnt_ff <= 1'b1;
            if (mod_cnt_ff) begin
               mod_busy_ff <= 1'b0;
               yaw_ff      <= yaw_fix;
            end
         end
         if (cmd.pstep) begin
            if (pitch_sum > PLIM) begin
               pitch_ff <= PLIM[23:0];
            end else if (pitch_sum < -PLIM) begin
               pitch_ff <= 24'(-PLIM);
            end else begin
               pitch_ff <= pitch_sum[23:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         dp_ff <= req_delta_pitch;
         tx_ff <= req_target_x;
         ty_ff <= req_target_y;
         tz_ff <= req_target_z;
      end
      if (cmd.ystep) begin
         mod_hi_ff <= yaw_hi_sum[22:0];
         mod_lo_ff <= yaw_sum[18:0];
      end else if (mod_busy_ff && !mod_cnt_ff) begin
         mod_q_ff <= mod_prod[44:28];
      end
      if (sin_done) sin_ff[cmd.sin_sel] <= sin_res;
      if (cmd.mul_en) begin
         case (cmd.mstep)
            4'd1: dcp_ff <= shv;
            4'd2: cy_ff  <= sat32(34'(ty_ff) + 34'(lift_ff) + 34'(shv));
            4'd3: cx_ff  <= sat32(34'(tx_ff) + 34'(shv));
            4'd4: cz_ff  <= sat32(34'(tz_ff) + 34'(shv));
            4'd5: qx_ff  <= to_q15(33'(shv));
            4'd6: qy_ff  <= to_q15(33'(shv));
            4'd7: qz_ff  <= to_q15(-33'(shv));
            4'd8: qw_ff  <= to_q15(33'(shv));
            default: dcp_ff <= dcp_ff;
         endcase
      end
      if (cmd.out_load) begin
         rsp_cam_x  <= cx_ff;
         rsp_cam_y  <= cy_ff;
         rsp_cam_z  <= cz_ff;
         rsp_quat_x <= qx_ff;
         rsp_quat_y <= qy_ff;
         rsp_quat_z <= qz_ff;
         rsp_quat_w <= qw_ff;
      end
   end

endmodule

### rtl/core/ocp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocp_ctrl
// sequencer: steps one frame through the datapath and owns the handshakes
// ---------------------------------------------------------------------------
module ocp_ctrl import ocp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output ocp_cmd_type    cmd,
   input  ocp_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_YSTEP = 3'd1;
   localparam logic [2:0] ST_PSTEP = 3'd2;
   localparam logic [2:0] ST_MODW  = 3'd3;
   localparam logic [2:0] ST_SGO   = 3'd4;
   localparam logic [2:0] ST_SWAIT = 3'd5;
   localparam logic [2:0] ST_MUL   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [3:0] m_ff, m_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.sin_sel  = k_ff;
      cmd.mstep    = m_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_YSTEP;
         end
         ST_YSTEP: begin
            cmd.ystep = 1'b1;
            state_in  = ST_PSTEP;
         end
         ST_PSTEP: begin
            cmd.pstep = 1'b1;
            state_in  = ST_MODW;
         end
         ST_MODW: if (!status.mod_busy) begin
            k_in     = '0;
            state_in = ST_SGO;
         end
         ST_SGO: begin
            cmd.sin_go = 1'b1;
            state_in   = ST_SWAIT;
         end
         ST_SWAIT: if (status.sin_done) begin
            if (k_ff == SIN_LAST) begin
               m_in     = '0;
               state_in = ST_MUL;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_SGO;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            m_in       = m_ff + 4'd1;
            if (m_ff == MSTEP_LAST) state_in = ST_OUT;
         end
         ST_OUT: if (slot_free) begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while still held");

   a_sin_wait: assert property (@(posedge clock) disable iff (reset)
      status.sin_done |-> (state_ff == ST_SWAIT))
      else $error("sine result arrived outside wait state");

   a_mod_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SGO || state_ff == ST_SWAIT || state_ff == ST_MUL)
      |-> !status.mod_busy)
      else $error("yaw remainder still running during trig");

   a_accept_go: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_YSTEP))
      else $error("accepted word did not start a frame");

endmodule

### rtl/core/orbit_camera_pose_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orbit_camera_pose_top
// third-person orbit camera: one frame word in, camera position and
// look-at quaternion out
// ---------------------------------------------------------------------------
// One frame is handled at a time: both angle steps are taken and the yaw is
// wrapped (a small reciprocal multiply and one compare and subtract), then
// eight sines and cosines go one after another through a single iterative
// sine unit, nine passes of the shared 33x33 multiplier form the position
// and quaternion, and the output register is loaded last. The finished word
// sits in that output register, so the next frame word is taken while a
// result still waits. Csr writes take effect at once and are meant for idle
// time only.
// ---------------------------------------------------------------------------
module orbit_camera_pose_top import ocp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // csr write port
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   // frame word in
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_delta_yaw,
   input  logic signed [31:0] req_delta_pitch,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   // pose word out
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_cam_x,
   output logic signed [31:0] rsp_cam_y,
   output logic signed [31:0] rsp_cam_z,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);

   // sequencer commands and datapath status
   ocp_cmd_type    cmd;
   ocp_status_type status;

   // control: handshakes and frame sequencing
   ocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: angles, trig, position and quaternion
   ocp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_delta_yaw    (req_delta_yaw),
      .req_delta_pitch  (req_delta_pitch),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_z     (req_target_z),
      .rsp_cam_x        (rsp_cam_x),
      .rsp_cam_y        (rsp_cam_y),
      .rsp_cam_z        (rsp_cam_z),
      .rsp_quat_x       (rsp_quat_x),
      .rsp_quat_y       (rsp_quat_y),
      .rsp_quat_z       (rsp_quat_z),
      .rsp_quat_w       (rsp_quat_w)
   );

endmodule

### verif/tb_orbit_camera_pose_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_orbit_camera_pose_top
// self-checking bench for the orbit camera pose block
// ---------------------------------------------------------------------------
// Frame words go in through a bursty sender and pose words come out through a
// receiver that stalls on a pattern of its own. Every accepted frame word
// runs through a fixed-point pose model kept in this bench, and every
// accepted pose word is checked field by field against the oldest
// prediction. A short table of hand-picked frames comes first. Random frames
// then run under several csr settings, including the extremes.
// ---------------------------------------------------------------------------
module tb_orbit_camera_pose_top;
   import ocp_pkg::*;

   localparam longint DEG16     = 65536;
   localparam longint DEG17     = 131072;
   localparam longint ONE_Q30   = 64'd1 << 30;
   localparam longint CYCLE_CAP = 4000000;
   localparam int     DRAIN_CYCLES = 400;   // longer than one frame time

   typedef struct {
      logic signed [31:0] dy, dp, tx, ty, tz;
   } frame_t;

   typedef struct {
      logic signed [31:0] cx, cy, cz;
      logic signed [15:0] qx, qy, qz, qw;
   } pose_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = CSR_YAW_GAIN;
   logic [31:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_delta_yaw = '0, req_delta_pitch = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_cam_x, rsp_cam_y, rsp_cam_z;
   logic signed [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   orbit_camera_pose_top u_top (.*);

   // clock, period 2 ns
   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // pose model: own copy of the csr values and of the two angles
   // ------------------------------------------------------------------------
   longint yaw_gain_m, pitch_gain_m, lift_m, distance_m;
   longint yaw_m, pitch_m;     // yaw Q9.16 degrees, pitch Q8.16 degrees

   pose_t  pose_queue[$];
   int     mismatch_count = 0;
   int     frames_sent = 0;
   int     poses_checked = 0;
   int     clamp_hits = 0;
   longint cycle_count = 0;
   int     hold_cycles = 0;   // long receiver hold-off, counted by receiver

   // sine in Q2.30 of an angle in 2^-17 degree
   function automatic longint sine_q30(longint a);
      longint full;
      bit neg;
      longint unsigned x, x2, t, s;
      longint unsigned divs[5];
      full = 360 * DEG17;
      divs = '{110, 72, 42, 20, 6};
      neg = 0;
      a = a % full;
      if (a < 0) a += full;
      if (a >= 180 * DEG17) begin
         a -= 180 * DEG17;
         neg = 1;
      end
      if (a > 90 * DEG17) a = 180 * DEG17 - a;
      x = (longint'(a) * 18740330) >> 17;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int i = 0; i < 5; i++) t = ONE_Q30 - ((x2 * t) >> 30) / divs[i];
      s = (x * t) >> 30;
      if (s > ONE_Q30) s = ONE_Q30;
      return neg ? -longint'(s) : longint'(s);
   endfunction

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] to_q15(longint v);
      longint r;
      r = (v + (64'sd1 << 14)) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // advance the angles by one frame and work out the pose word
   function automatic pose_t frame_pose(frame_t f);
      pose_t p;
      longint sy, cy, sp, cp, dcp, ha, sa, ca, sb, cb;
      yaw_m += (longint'(f.dy) * yaw_gain_m) >>> 16;
      yaw_m = yaw_m % (360 * DEG16);
      if (yaw_m < 0) yaw_m += 360 * DEG16;
      pitch_m -= (longint'(f.dp) * pitch_gain_m) >>> 16;
      if (pitch_m > 89 * DEG16) begin
         pitch_m = 89 * DEG16;
         clamp_hits++;
      end else if (pitch_m < -89 * DEG16) begin
         pitch_m = -89 * DEG16;
         clamp_hits++;
      end
      sy = sine_q30(yaw_m * 2);
      cy = sine_q30(yaw_m * 2 + 90 * DEG17);
      sp = sine_q30(pitch_m * 2);
      cp = sine_q30(pitch_m * 2 + 90 * DEG17);
      dcp = (distance_m * cp) >>> 30;
      p.cx = sat32(longint'(f.tx) + ((dcp * sy) >>> 30));
      p.cy = sat32(longint'(f.ty) + lift_m + ((distance_m * sp) >>> 30));
      p.cz = sat32(longint'(f.tz) + ((dcp * cy) >>> 30));
      // half angles: 2^-16 degree units read as halves in 2^-17 units
      ha = yaw_m + 180 * DEG16;
      if (ha > 90 * DEG17) ha -= 180 * DEG17;
      sa = sine_q30(ha);
      ca = sine_q30(ha + 90 * DEG17);
      sb = sine_q30(pitch_m);
      cb = sine_q30(pitch_m + 90 * DEG17);
      p.qx = to_q15((ca * sb) >>> 30);
      p.qy = to_q15((sa * cb) >>> 30);
      p.qz = to_q15(-((sa * sb) >>> 30));
      p.qw = to_q15((ca * cb) >>> 30);
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("mismatch pose %0d %s: got %0d expected %0d",
               poses_checked, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // monitors: predict on frame accept, check on pose accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pose_t want;
      frame_t f;
      cycle_count++;
      if (!reset && req_valid && !req_stall) begin
         f.dy = req_delta_yaw;  f.dp = req_delta_pitch;
         f.tx = req_target_x;   f.ty = req_target_y;   f.tz = req_target_z;
         pose_queue.push_back(frame_pose(f));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            want = pose_queue.pop_front();
            if (rsp_cam_x !== want.cx) report_mismatch("cam_x", rsp_cam_x, want.cx);
            if (rsp_cam_y !== want.cy) report_mismatch("cam_y", rsp_cam_y, want.cy);
            if (rsp_cam_z !== want.cz) report_mismatch("cam_z", rsp_cam_z, want.cz);
            if (rsp_quat_x !== want.qx) report_mismatch("quat_x", rsp_quat_x, want.qx);
            if (rsp_quat_y !== want.qy) report_mismatch("quat_y", rsp_quat_y, want.qy);
            if (rsp_quat_z !== want.qz) report_mismatch("quat_z", rsp_quat_z, want.qz);
            if (rsp_quat_w !== want.qw) report_mismatch("quat_w", rsp_quat_w, want.qw);
            // first word after reset at zero angles: read straight off the math,
            // yaw zero gives w zero and no x or z part, camera x stays on target
            if (poses_checked == 0) begin
               if (rsp_cam_x !== 32'sd0) report_mismatch("first cam_x", rsp_cam_x, 0);
               if (rsp_quat_x !== 16'sd0) report_mismatch("first quat_x", rsp_quat_x, 0);
               if (rsp_quat_z !== 16'sd0) report_mismatch("first quat_z", rsp_quat_z, 0);
               if (rsp_quat_w !== 16'sd0) report_mismatch("first quat_w", rsp_quat_w, 0);
            end
         end
         poses_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pose_queue.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: stall pattern changes every so often, plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int mode, left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(50, 2000);
         end
         left--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;                              // free flow
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 15) < 13); // heavy
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender helpers
   // ------------------------------------------------------------------------
   // drive one frame word and hold it until taken; caller is at a clock edge
   task automatic send_frame(frame_t f);
      req_valid <= 1'b1;
      req_delta_yaw <= f.dy;
      req_delta_pitch <= f.dp;
      req_target_x <= f.tx;
      req_target_y <= f.ty;
      req_target_z <= f.tz;
      do @(posedge clock); while (req_stall);
      frames_sent++;
   endtask

   // wait for all words home, let the block settle, then write one register
   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_YAW_GAIN:   yaw_gain_m = value[23:0];
         CSR_PITCH_GAIN: pitch_gain_m = value[23:0];
         CSR_LIFT:       lift_m = longint'($signed(value));
         default:        distance_m = value[30:0];
      endcase
   endtask

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // mostly small frame-to-frame moves, some full-range noise, extremes and frames without movement
   function automatic frame_t random_frame();
      frame_t f;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         f.dy = $signed($urandom_range(0, 60 * 65536)) - 30 * 65536;
         f.dp = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
         f.tx = $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
         f.ty = $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
         f.tz = $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
      end else if (kind == 7) begin
         f.dy = $urandom; f.dp = $urandom;
         f.tx = $urandom; f.ty = $urandom; f.tz = $urandom;
      end else if (kind == 8) begin
         f.dy = pick_extreme(); f.dp = pick_extreme();
         f.tx = pick_extreme(); f.ty = pick_extreme(); f.tz = pick_extreme();
      end else begin
         // no movement, only the target wanders
         f.dy = 0; f.dp = 0;
         f.tx = $urandom; f.ty = $urandom; f.tz = $urandom;
      end
      return f;
   endfunction

   // random frames in bursts with random gaps between them
   task automatic send_random(int count);
      int burst, gap;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            send_frame(random_frame());
            burst--;
            count--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      frame_t directed[$];
      int gap;

      yaw_gain_m = 65536;
      pitch_gain_m = 65536;
      lift_m = 65536;
      distance_m = 327680;
      yaw_m = 0;
      pitch_m = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: dy, dp, tx, ty, tz
      directed = '{
         '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},                 // at rest
         '{32'sd90 <<< 16, 32'sd0, 32'sd0, 32'sd0, 32'sd0},         // quarter turn
         '{-(32'sd450 <<< 16), 32'sd0, 32'sd0, 32'sd0, 32'sd0},     // negative wrap
         '{32'sd270 <<< 16, 32'sd0, 32'sd0, 32'sd0, 32'sd0},        // yaw to 270 degrees
         '{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0},          // largest step
         '{32'h8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0},          // most negative step
         '{32'sd0, 32'sd100 <<< 16, 32'sd0, 32'sd0, 32'sd0},        // pitch clamp low
         '{32'sd0, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0},          // pitch clamp high
         '{32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0},          // full swing down
         '{32'sd0, -(32'sd89 <<< 16), 32'sd0, 32'sd0, 32'sd0},      // back to level
         '{32'sd45 <<< 16, 32'sd30 <<< 16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
         '{32'sd0, -(32'sd60 <<< 16), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
         '{32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1},               // smallest steps
         '{-32'sd1, 32'sd1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA},
         '{32'sd180 <<< 16, 32'sd0, 32'h1234_5678, -32'sd65536, 32'sd0}
      };
      foreach (directed[i]) begin
         send_frame(directed[i]);
         gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // default settings, with one long receiver hold-off so the block backs up
      hold_cycles = 3000;
      send_random(300);

      // every register at its top value
      write_csr(CSR_YAW_GAIN, 32'h00FF_FFFF);
      write_csr(CSR_PITCH_GAIN, 32'h00FF_FFFF);
      write_csr(CSR_LIFT, 32'h7FFF_FFFF);
      write_csr(CSR_DISTANCE, 32'h7FFF_FFFF);
      send_random(300);

      // bottom values: frozen angles, camera on the lifted target
      write_csr(CSR_YAW_GAIN, 32'h0);
      write_csr(CSR_PITCH_GAIN, 32'h0);
      write_csr(CSR_LIFT, 32'h8000_0000);
      write_csr(CSR_DISTANCE, 32'h0);
      send_random(200);

      // a few random settings near unit gain, then fully random ones
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_YAW_GAIN, phase < 2 ? $urandom_range(0, 4 * 65536) : $urandom);
         write_csr(CSR_PITCH_GAIN, phase < 2 ? $urandom_range(0, 4 * 65536) : $urandom);
         write_csr(CSR_LIFT, $urandom);
         write_csr(CSR_DISTANCE, phase < 2 ? $urandom_range(0, 1000 * 65536) : $urandom);
         send_random(270);
      end

      // drain
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d frame words and %0d pose words in %0d cycles",
               frames_sent, poses_checked, cycle_count);
      $display("pitch limit reached %0d times, %0d mismatches", clamp_hits, mismatch_count);
      if (mismatch_count == 0 && pose_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### orbit_camera_pose_top.f
rtl/core/ocp_pkg.sv
rtl/core/ocp_sin.sv
rtl/core/ocp_dp.sv
rtl/core/ocp_ctrl.sv
rtl/core/orbit_camera_pose_top.sv
verif/tb_orbit_camera_pose_top.sv
